// File: hdl/pidpc_pkg.sv
package pidpc_pkg;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_TARGET_POSITION = 3'd0,
        REG_GAIN_P          = 3'd1,
        REG_GAIN_I          = 3'd2,
        REG_GAIN_D          = 3'd3,
        REG_WINDUP_LIMIT    = 3'd4
    } cfg_reg_t;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    // Windup limit after reset: 40.0 in Q16.16.
    localparam logic [30:0] WINDUP_RESET = 31'd2621440;

    // The full PID sum is an exact Q.32 value that fits in 82 bits.
    localparam int SUM_W  = 82;
    localparam int FRAC_W = 32;
    localparam int INT_W  = SUM_W - FRAC_W;

    localparam int POWER_LIMIT = 100;

    // Error, updated integral and derivative of one sample.
    typedef struct packed {
        logic signed [31:0] err;
        logic signed [47:0] integ;
        logic signed [32:0] deriv;
    } front_t;

endpackage

// File: hdl/pidpc_front.sv
module pidpc_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [31:0]   in_position,
    input  logic signed [31:0]   target_position,
    input  logic [30:0]          windup_limit,
    output logic                 out_valid,
    input  logic                 out_ready,
    output pidpc_pkg::front_t    out_data
);
    import pidpc_pkg::*;

    logic               ready0, ready1, ready2;
    logic               v0_reg, v1_reg, v2_reg;
    logic signed [31:0] pos_reg;
    logic signed [31:0] err1_reg, err1_next;
    logic               clr1_reg, clr1_next;
    front_t             out_reg, out_next;
    logic signed [47:0] integ_reg;
    logic signed [31:0] prev_err_reg;

    logic signed [32:0] diff;
    logic [31:0]        err_mag;
    logic               windup;
    logic signed [48:0] integ_sum;
    logic signed [47:0] integ_sat;

    assign ready2   = !v2_reg || out_ready;
    assign ready1   = !v1_reg || ready2;
    assign ready0   = !v0_reg || ready1;
    assign in_ready = ready0;

    // Stage 1: saturated error and the zero and overshoot tests.
    always_comb begin
        diff = {target_position[31], target_position} - {pos_reg[31], pos_reg};
        if (diff[32] != diff[31]) begin
            err1_next = diff[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            err1_next = diff[31:0];
        end
        // A negative difference means the position lies above the setpoint.
        clr1_next = diff[32] || (diff == '0);
    end

    // Stage 2: windup test, saturating integral and derivative.
    always_comb begin
        err_mag   = err1_reg[31] ? (32'd0 - 32'(err1_reg)) : 32'(err1_reg);
        windup    = err_mag > {1'b0, windup_limit};
        integ_sum = {integ_reg[47], integ_reg} + {{17{err1_reg[31]}}, err1_reg};
        if (integ_sum[48] != integ_sum[47]) begin
            integ_sat = integ_sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
        end else begin
            integ_sat = integ_sum[47:0];
        end
        out_next.err   = err1_reg;
        out_next.integ = (clr1_reg || windup) ? 48'sd0 : integ_sat;
        out_next.deriv = {err1_reg[31], err1_reg} - {prev_err_reg[31], prev_err_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg       <= 1'b0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            integ_reg    <= '0;
            prev_err_reg <= '0;
        end else begin
            if (ready0) begin
                v0_reg <= in_valid;
            end
            if (ready1) begin
                v1_reg <= v0_reg;
            end
            if (ready2) begin
                v2_reg <= v1_reg;
            end
            // The loop state moves exactly once per sample, when it enters stage 2.
            if (v1_reg && ready2) begin
                integ_reg    <= out_next.integ;
                prev_err_reg <= err1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && ready0) begin
            pos_reg <= in_position;
        end
        if (v0_reg && ready1) begin
            err1_reg <= err1_next;
            clr1_reg <= clr1_next;
        end
        if (v1_reg && ready2) begin
            out_reg <= out_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_data  = out_reg;

    a_integ_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && ready2 && clr1_reg) |=> (integ_reg == 48'sd0))
        else $error("integral not cleared after zero error or overshoot");

    a_prev_err: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && ready2) |=> (prev_err_reg == $past(err1_reg)))
        else $error("previous error not taken from the sample in stage 2");

endmodule

// File: hdl/pidpc_mac.sv
module pidpc_mac (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  pidpc_pkg::front_t                 in_data,
    input  logic signed [31:0]                gain_p,
    input  logic signed [31:0]                gain_i,
    input  logic signed [31:0]                gain_d,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [pidpc_pkg::SUM_W-1:0] out_sum
);
    import pidpc_pkg::*;

    logic ready3, ready4, ready5;
    logic v3_reg, v4_reg, v5_reg;

    // Stage 3 products. The 48-bit integral is split into a signed upper
    // 16 bits and an unsigned lower 32-bit word.
    logic signed [63:0] pp_reg, pp_next;
    logic signed [64:0] pd_reg, pd_next;
    logic signed [64:0] pil_reg, pil_next;
    logic signed [47:0] pih_reg, pih_next;
    logic signed [15:0] integ_hi;
    logic signed [32:0] integ_lo;

    logic signed [SUM_W-1:0] sum1_reg, sum1_next;
    logic signed [SUM_W-1:0] sum2_reg, sum2_next;
    logic signed [SUM_W-1:0] total_reg, total_next;

    assign ready5   = !v5_reg || out_ready;
    assign ready4   = !v4_reg || ready5;
    assign ready3   = !v3_reg || ready4;
    assign in_ready = ready3;

    assign integ_hi = in_data.integ[47:32];
    assign integ_lo = {1'b0, in_data.integ[31:0]};

    assign pp_next  = gain_p * in_data.err;
    assign pd_next  = gain_d * in_data.deriv;
    assign pil_next = gain_i * integ_lo;
    assign pih_next = gain_i * integ_hi;

    assign sum1_next = {{(SUM_W-64){pp_reg[63]}}, pp_reg}
                     + {{(SUM_W-65){pd_reg[64]}}, pd_reg};
    assign sum2_next = {{(SUM_W-65){pil_reg[64]}}, pil_reg}
                     + {{(SUM_W-80){pih_reg[47]}}, pih_reg, 32'd0};
    assign total_next = sum1_reg + sum2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (ready3) begin
                v3_reg <= in_valid;
            end
            if (ready4) begin
                v4_reg <= v3_reg;
            end
            if (ready5) begin
                v5_reg <= v4_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && ready3) begin
            pp_reg  <= pp_next;
            pd_reg  <= pd_next;
            pil_reg <= pil_next;
            pih_reg <= pih_next;
        end
        if (v3_reg && ready4) begin
            sum1_reg <= sum1_next;
            sum2_reg <= sum2_next;
        end
        if (v4_reg && ready5) begin
            total_reg <= total_next;
        end
    end

    assign out_valid = v5_reg;
    assign out_sum   = total_reg;

endmodule

// File: hdl/pidpc_limit.sv
module pidpc_limit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [pidpc_pkg::SUM_W-1:0] in_sum,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [7:0]                 drive_power,
    output logic                              power_saturated
);
    import pidpc_pkg::*;

    localparam logic signed [INT_W-1:0] LIM_HI = INT_W'(POWER_LIMIT);
    localparam logic signed [INT_W-1:0] LIM_LO = -LIM_HI;

    logic                    v6_reg;
    logic                    round_up;
    logic signed [INT_W-1:0] trunc;
    logic                    sat_hi, sat_lo;
    logic signed [7:0]       power_reg, power_next;
    logic                    sat_reg, sat_next;

    // Truncation toward zero: a negative value with a fraction moves up by one.
    assign round_up = in_sum[SUM_W-1] && (in_sum[FRAC_W-1:0] != '0);
    assign trunc    = $signed(in_sum[SUM_W-1:FRAC_W])
                    + $signed({{(INT_W-1){1'b0}}, round_up});
    assign sat_hi   = trunc > LIM_HI;
    assign sat_lo   = trunc < LIM_LO;

    always_comb begin
        sat_next = sat_hi || sat_lo;
        if (sat_hi) begin
            power_next = LIM_HI[7:0];
        end else if (sat_lo) begin
            power_next = LIM_LO[7:0];
        end else begin
            power_next = trunc[7:0];
        end
    end

    assign in_ready = !v6_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v6_reg <= 1'b0;
        end else if (in_ready) begin
            v6_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            power_reg <= power_next;
            sat_reg   <= sat_next;
        end
    end

    assign out_valid       = v6_reg;
    assign drive_power     = power_reg;
    assign power_saturated = sat_reg;

    a_power_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid |-> (drive_power <= $signed(LIM_HI[7:0])
                       && drive_power >= $signed(LIM_LO[7:0])))
        else $error("drive power outside the percent range");

    a_sat_at_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && power_saturated) |->
            (drive_power == LIM_HI[7:0] || drive_power == LIM_LO[7:0]))
        else $error("saturated result not at the limit");

endmodule

// File: hdl/pid_position_controller_core.sv
// Channel   Direction  tdata (low bit up)            tuser
// s_        in         measured_position [31:0]      -
// m_        out        drive_power [7:0]             power_saturated [0]
// cfg_      in         write enable, index, data     -
//
// One sample is accepted per clock while the pipeline is not stalled; each result passes
// through seven register stages before it is valid.
// The integral and previous error update in one stage, so samples follow back to back.
// Every stage holds its item while the next one is full; empty stages keep filling.
// Active-low sync reset clears pipeline, loop state, target and gains; windup is 40.0.
module pid_position_controller_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [31:0]                          s_tdata,  // [31:0] measured_position
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [7:0]                           m_tdata,  // [7:0] drive_power
    output logic [0:0]                           m_tuser,  // [0] power_saturated
    input  logic                                 cfg_wr_en,
    input  logic [pidpc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [pidpc_pkg::CFG_DATA_W-1:0]     cfg_wr_data
);
    import pidpc_pkg::*;

    logic signed [31:0] target_reg;
    logic signed [31:0] gain_p_reg;
    logic signed [31:0] gain_i_reg;
    logic signed [31:0] gain_d_reg;
    logic [30:0]        windup_reg;

    logic               front_valid, front_ready;
    front_t             front_data;
    logic               mac_valid, mac_ready;
    logic signed [SUM_W-1:0] mac_sum;
    logic signed [7:0]  drive_power;
    logic               power_saturated;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg <= '0;
            gain_p_reg <= '0;
            gain_i_reg <= '0;
            gain_d_reg <= '0;
            windup_reg <= WINDUP_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_TARGET_POSITION: target_reg <= cfg_wr_data;
                REG_GAIN_P:          gain_p_reg <= cfg_wr_data;
                REG_GAIN_I:          gain_i_reg <= cfg_wr_data;
                REG_GAIN_D:          gain_d_reg <= cfg_wr_data;
                REG_WINDUP_LIMIT:    windup_reg <= cfg_wr_data[30:0];
                default: begin
                end
            endcase
        end
    end

    pidpc_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_valid        (s_tvalid),
        .in_ready        (s_tready),
        .in_position     (s_tdata),
        .target_position (target_reg),
        .windup_limit    (windup_reg),
        .out_valid       (front_valid),
        .out_ready       (front_ready),
        .out_data        (front_data)
    );

    pidpc_mac u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_data   (front_data),
        .gain_p    (gain_p_reg),
        .gain_i    (gain_i_reg),
        .gain_d    (gain_d_reg),
        .out_valid (mac_valid),
        .out_ready (mac_ready),
        .out_sum   (mac_sum)
    );

    pidpc_limit u_limit (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_valid        (mac_valid),
        .in_ready        (mac_ready),
        .in_sum          (mac_sum),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .drive_power     (drive_power),
        .power_saturated (power_saturated)
    );

    assign m_tdata    = drive_power;
    assign m_tuser[0] = power_saturated;

    // The input side can only stall when the whole pipeline is full behind a
    // result that is not taken.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled while the output is free");

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import pidpc_pkg::*;

    localparam int          STALL_CYCLES  = 60;
    localparam int          SETTLE_CYCLES = 12;
    localparam int          MOTION_ITEMS  = 72;
    localparam int          WINDUP_ITEMS  = 24;
    localparam int          PRINT_CAP     = 40;
    localparam logic [31:0] ONE_Q         = 32'h0001_0000;
    localparam logic [31:0] MAX_Q         = 32'h7FFF_FFFF;
    localparam logic [31:0] MIN_Q         = 32'h8000_0000;

    typedef struct packed {
        logic signed [7:0] power;
        logic              saturated;
    } drive_cmd_t;

    logic                   aclk        = 1'b0;
    logic                   aresetn     = 1'b0;
    logic                   s_tvalid    = 1'b0;
    logic                   s_tready;
    logic [31:0]            s_tdata     = '0;
    logic                   m_tvalid;
    logic                   m_tready    = 1'b0;
    logic [7:0]             m_tdata;
    logic [0:0]             m_tuser;
    logic                   cfg_wr_en   = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  cfg_wr_data = '0;

    // Local copy of the controller registers and loop state.
    logic signed [31:0] setpoint_q   = '0;
    logic signed [31:0] kp_q         = '0;
    logic signed [31:0] ki_q         = '0;
    logic signed [31:0] kd_q         = '0;
    logic [30:0]        windup_q     = WINDUP_RESET;
    logic signed [47:0] integral_acc = '0;
    logic signed [31:0] last_error   = '0;

    logic [31:0] samples_to_send[$];
    drive_cmd_t  drive_cmds_due[$];
    int          drive_mismatches = 0;
    int          send_idle_pct    = 32;
    int          recv_idle_pct    = 49;
    int          stall_requests   = 0;
    int          stall_served     = 0;
    int          stall_left       = 0;

    pid_position_controller_core uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

    task automatic report_mismatch(input string what);
        if (drive_mismatches < PRINT_CAP) begin
            $display("%0t: mismatch: %s", $realtime, what);
        end
        drive_mismatches++;
    endtask

    // Runs one control tick on the local state and returns the expected command.
    function automatic drive_cmd_t compute_drive(input logic [31:0] sample);
        logic signed [31:0] position;
        logic signed [31:0] err;
        logic signed [32:0] err_wide;
        logic signed [32:0] err_ext;
        logic [32:0]        err_mag;
        logic signed [32:0] deriv;
        logic signed [48:0] integ_wide;
        logic signed [47:0] integ;
        logic signed [95:0] total;
        logic [95:0]        total_mag;
        logic [63:0]        whole;
        logic [7:0]         mag8;
        logic               neg;
        drive_cmd_t         cmd;
        position = sample;
        err_wide = setpoint_q - position;
        if (err_wide[32] != err_wide[31]) begin
            err = err_wide[32] ? MIN_Q : MAX_Q;
        end else begin
            err = err_wide[31:0];
        end
        integ_wide = integral_acc + err;
        if (integ_wide[48] != integ_wide[47]) begin
            integ = integ_wide[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
        end else begin
            integ = integ_wide[47:0];
        end
        // The overshoot test looks at the raw values, not the clipped error.
        if (err == 0 || position > setpoint_q) begin
            integ = '0;
        end
        err_ext = err;
        err_mag = (err_ext < 0) ? -err_ext : err_ext;
        if (err_mag > {2'b00, windup_q}) begin
            integ = '0;
        end
        integral_acc = integ;
        deriv = err - last_error;
        last_error = err;
        total = kp_q * err + ki_q * integ + kd_q * deriv;
        neg = total[95];
        total_mag = neg ? -total : total;
        whole = total_mag[95:32];
        cmd.saturated = (whole > POWER_LIMIT);
        mag8 = cmd.saturated ? 8'(POWER_LIMIT) : whole[7:0];
        cmd.power = neg ? -mag8 : mag8;
        return cmd;
    endfunction

    always @(posedge aclk) begin : drive_samples
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                drive_cmds_due.push_back(compute_drive(s_tdata));
            end
            if (!s_tvalid || s_tready) begin
                if (samples_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= samples_to_send.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : check_drive
        drive_cmd_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (drive_cmds_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected power %0d", $signed(m_tdata)));
                end else begin
                    want = drive_cmds_due.pop_front();
                    if (m_tdata !== want.power) begin
                        report_mismatch($sformatf("drive_power %0d, want %0d",
                                                  $signed(m_tdata), want.power));
                    end
                    if (m_tuser[0] !== want.saturated) begin
                        report_mismatch($sformatf("power_saturated %b, want %b",
                                                  m_tuser[0], want.saturated));
                    end
                end
            end
            if (stall_left == 0 && stall_served != stall_requests) begin
                stall_left = STALL_CYCLES;
                stall_served++;
            end
            if (stall_left != 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (cfg_reg_t'(idx))
            REG_TARGET_POSITION: setpoint_q = value;
            REG_GAIN_P:          kp_q = value;
            REG_GAIN_I:          ki_q = value;
            REG_GAIN_D:          kd_q = value;
            REG_WINDUP_LIMIT:    windup_q = value[30:0];
            default: ;
        endcase
    endtask

    task automatic set_all(input logic [31:0] target, input logic [31:0] kp,
                           input logic [31:0] ki, input logic [31:0] kd,
                           input logic [31:0] windup);
        write_reg(REG_TARGET_POSITION, target);
        write_reg(REG_GAIN_P, kp);
        write_reg(REG_GAIN_I, ki);
        write_reg(REG_GAIN_D, kd);
        write_reg(REG_WINDUP_LIMIT, windup);
    endtask

    task automatic wait_idle();
        do @(negedge aclk);
        while (samples_to_send.size() != 0 || s_tvalid || drive_cmds_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    function automatic logic [31:0] pick_gain(input int top);
        logic signed [31:0] g;
        case ($urandom_range(0, 7))
            0:       g = $urandom;
            1:       g = '0;
            default: g = $urandom_range(0, top << 16);
        endcase
        if ($urandom_range(0, 3) == 0) begin
            g = -g;
        end
        return g;
    endfunction

    // Moves toward the setpoint from a random distance, with noise and occasional
    // overshoot, exact arrivals and stray samples mixed in.
    task automatic queue_motion(input int count);
        longint gap;
        longint where;
        int     left;
        left = 0;
        gap  = 0;
        repeat (count) begin
            if (left == 0) begin
                left = $urandom_range(8, 30);
                gap  = longint'($urandom_range(0, 60 << 16));
                if ($urandom_range(0, 3) == 0) begin
                    gap = gap - longint'(30 << 16);
                end
            end
            left--;
            if ($urandom_range(0, 15) == 0) begin
                gap = 0;
            end
            if ($urandom_range(0, 9) < 2) begin
                samples_to_send.push_back($urandom);
            end else begin
                where = longint'(setpoint_q) - gap;
                if (where > 64'sd2147483647) where = 64'sd2147483647;
                if (where < -64'sd2147483648) where = -64'sd2147483648;
                samples_to_send.push_back(where[31:0]);
            end
            gap = gap * 3 / 4 + longint'($urandom_range(0, 1 << 16)) - longint'(1 << 15);
        end
    endtask

    initial begin
        logic [31:0] target;
        logic [31:0] windup;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Registers at their reset values: zero gains, but the loop state still moves.
        samples_to_send.push_back(32'h0);
        samples_to_send.push_back(MAX_Q);
        samples_to_send.push_back(MIN_Q);
        samples_to_send.push_back($urandom);
        wait_idle();

        // Fractional excess, clipping both ways, error overflow and the windup boundary.
        set_all(32'h0, ONE_Q, 32'h0, 32'h0, 32'(WINDUP_RESET));
        samples_to_send.push_back(32'h0);
        samples_to_send.push_back(-((100 << 16) + 32'h8000));
        samples_to_send.push_back(-(101 << 16));
        samples_to_send.push_back((100 << 16) + 32'h8000);
        samples_to_send.push_back((101 << 16));
        samples_to_send.push_back(MIN_Q);
        samples_to_send.push_back(MAX_Q);
        wait_idle();
        write_reg(REG_GAIN_I, ONE_Q);
        samples_to_send.push_back(-32'(WINDUP_RESET));
        samples_to_send.push_back(-32'(WINDUP_RESET));
        samples_to_send.push_back(-32'(WINDUP_RESET) - 1);
        samples_to_send.push_back(32'h1);
        wait_idle();

        set_all(MAX_Q, ONE_Q >> 1, ONE_Q >> 2, ONE_Q << 1, MAX_Q);
        samples_to_send.push_back(MIN_Q);
        samples_to_send.push_back(MAX_Q);
        samples_to_send.push_back(32'h0);
        wait_idle();
        set_all(MIN_Q, -ONE_Q, ONE_Q, -(ONE_Q >> 1), MAX_Q);
        samples_to_send.push_back(MAX_Q);
        samples_to_send.push_back(MIN_Q);
        samples_to_send.push_back(32'hFFFF_FFFF);
        wait_idle();

        // Writes to indexes past the last register must leave everything alone.
        for (int idx = int'(REG_WINDUP_LIMIT) + 1; idx < (1 << CFG_INDEX_W); idx++) begin
            write_reg(CFG_INDEX_W'(idx), $urandom);
        end
        samples_to_send.push_back(32'h1234_5678);
        samples_to_send.push_back(MAX_Q);
        wait_idle();

        for (int k = 0; k < 7; k++) begin
            if (k == 3) begin
                send_idle_pct = 49;
                recv_idle_pct = 32;
            end else if (k == 6) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (k)
                1: set_all(MAX_Q, MAX_Q, MAX_Q, MAX_Q, 32'hFFFF_FFFF);
                4: set_all(MIN_Q, MIN_Q, MIN_Q, MIN_Q, 32'h0);
                default: begin
                    target = ($urandom_range(0, 3) == 0)
                           ? $urandom : $urandom_range(0, 200 << 16) - (100 << 16);
                    windup = ($urandom_range(0, 3) == 0)
                           ? $urandom : $urandom_range(0, 80 << 16);
                    set_all(target, pick_gain(20), pick_gain(2), pick_gain(10), windup);
                end
            endcase
            if (k == 2) begin
                // The sender goes quiet until the pipeline has drained.
                queue_motion(MOTION_ITEMS / 2);
                wait_idle();
                queue_motion(MOTION_ITEMS / 2);
            end else begin
                queue_motion(MOTION_ITEMS);
            end
            if (k == 6) begin
                // Hold the result side long enough for the pipeline to back up.
                do @(negedge aclk);
                while (drive_cmds_due.size() < 3);
                stall_requests++;
            end
            wait_idle();
        end

        // Maximum error every tick so the integral grows by the full error, then a
        // clearing tick.
        set_all(MAX_Q, 32'h0, 32'h1, 32'h0, MAX_Q);
        repeat (WINDUP_ITEMS) begin
            samples_to_send.push_back(-$urandom_range(0, 255));
        end
        samples_to_send.push_back(MAX_Q);
        samples_to_send.push_back(32'h0);
        wait_idle();

        if (drive_mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
